[src/dgs_pkg.sv]
package dgs_pkg;

   // lattice geometry
   localparam int GRID_W    = 1024;
   localparam int GRID_H    = 1024;
   localparam int XW        = $clog2(GRID_W);
   localparam int YW        = $clog2(GRID_H);
   localparam int LAT_DEPTH = GRID_W * GRID_H;
   localparam int ADDR_W    = $clog2(LAT_DEPTH);

   // fixed field widths
   localparam int POS_W  = 10;
   localparam int CELL_W = 2;
   localparam int DIR_W  = 3;
   localparam int MODE_W = 2;
   localparam int CNT_W  = 21;

   localparam logic [CNT_W-1:0] COUNT_MAX    = {CNT_W{1'b1}};
   localparam logic [CNT_W-1:0] TARGET_RESET = CNT_W'(10000);

   // cell codes
   localparam logic [CELL_W-1:0] CELL_EMPTY  = 2'd0;
   localparam logic [CELL_W-1:0] CELL_WALKER = 2'd1;
   localparam logic [CELL_W-1:0] CELL_AGG    = 2'd2;
   localparam logic [CELL_W-1:0] CELL_NONE   = 2'd3;

   // command codes
   localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_STEP  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_NOP   = 2'd3;

   // move directions, also the probe order of a step (center first)
   localparam logic [DIR_W-1:0] DIR_STAY  = 3'd0;
   localparam logic [DIR_W-1:0] DIR_UP    = 3'd1;
   localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd2;
   localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd3;
   localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_READ_ISSUE,
      ST_READ_TAKE,
      ST_PROBE,
      ST_DECIDE,
      ST_MOVE_CLR,
      ST_RESULT
   } ctrl_state_type;

   // packed so that mode sits in the lowest bits
   typedef struct packed {
      logic [DIR_W-1:0]  direction;
      logic [CELL_W-1:0] new_value;
      logic [POS_W-1:0]  pos_y;
      logic [POS_W-1:0]  pos_x;
      logic [MODE_W-1:0] mode;
   } req_item_type;

   typedef struct packed {
      logic              finished;
      logic              sweep_done;
      logic [CNT_W-1:0]  aggregate_count;
      logic              stuck;
      logic [CELL_W-1:0] read_value;
   } rsp_item_type;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [CELL_W-1:0] wr_data;
   } mem_req_type;

endpackage

[src/dgs_lattice_mem.sv]
module dgs_lattice_mem
   import dgs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  mem_req_type       mem_req,
   output logic [CELL_W-1:0] rd_data,
   output logic              clear_busy
);

   logic [CELL_W-1:0] lattice [LAT_DEPTH];
   logic [CELL_W-1:0] rd_data_ff;
   logic              clr_busy_ff;
   logic              clr_busy_in;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic [ADDR_W-1:0] clr_addr_in;

   // sweep every entry to empty once after reset
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(LAT_DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         lattice[clr_addr_ff] <= CELL_EMPTY;
      end else if (mem_req.wr_en) begin
         lattice[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= lattice[mem_req.rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clr_busy_ff;

endmodule

[src/dgs_sweep_ctrl.sv]
module dgs_sweep_ctrl
   import dgs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  req_item_type      in_item,
   input  logic [CNT_W-1:0]  target_count,
   output logic              res_valid,
   input  logic              res_ready,
   output rsp_item_type      res_item,
   output mem_req_type       mem_req,
   input  logic [CELL_W-1:0] rd_data,
   input  logic              clear_busy
);

   ctrl_state_type    state_ff, state_in;
   logic [XW-1:0]     scan_x_ff, scan_x_in;
   logic [YW-1:0]     scan_y_ff, scan_y_in;
   logic [CNT_W-1:0]  joined_ff, joined_in;
   logic              run_over_ff, run_over_in;
   logic [DIR_W-1:0]  probe_ff, probe_in;

   // per-transaction payload
   logic [XW-1:0]     cur_x_ff, cur_x_in;
   logic [YW-1:0]     cur_y_ff, cur_y_in;
   logic              inside_ff, inside_in;
   logic [CELL_W-1:0] nv_ff, nv_in;
   logic [DIR_W-1:0]  dir_ff, dir_in;
   logic [CELL_W-1:0] cells_ff [4];
   logic [CELL_W-1:0] cells_in [4];
   logic [CELL_W-1:0] read_value_ff, read_value_in;
   logic              stuck_ff, stuck_in;
   logic              done_ff, done_in;

   logic [DIR_W-1:0]  nb_sel;
   logic [XW-1:0]     nb_x;
   logic [YW-1:0]     nb_y;
   logic [ADDR_W-1:0] nb_addr;
   logic [ADDR_W-1:0] ctr_addr;
   logic              walker;
   logic              near_agg;
   logic              dir_moves;
   logic [CELL_W-1:0] tgt_cell;
   logic              move_ok;
   logic [CNT_W-1:0]  joined_inc;

   // neighbor coordinates wrap at the edges
   assign nb_sel = (state_ff == ST_PROBE) ? probe_ff : dir_ff;

   always_comb begin
      nb_x = cur_x_ff;
      nb_y = cur_y_ff;
      unique case (nb_sel)
         DIR_UP: begin
            nb_y = (cur_y_ff == '0) ? YW'(GRID_H - 1) : cur_y_ff - 1'b1;
         end
         DIR_RIGHT: begin
            nb_x = (cur_x_ff == XW'(GRID_W - 1)) ? '0 : cur_x_ff + 1'b1;
         end
         DIR_DOWN: begin
            nb_y = (cur_y_ff == YW'(GRID_H - 1)) ? '0 : cur_y_ff + 1'b1;
         end
         DIR_LEFT: begin
            nb_x = (cur_x_ff == '0) ? XW'(GRID_W - 1) : cur_x_ff - 1'b1;
         end
         default: begin
            nb_x = cur_x_ff;
         end
      endcase
   end

   assign nb_addr  = ADDR_W'(nb_x) * ADDR_W'(GRID_H) + ADDR_W'(nb_y);
   assign ctr_addr = ADDR_W'(cur_x_ff) * ADDR_W'(GRID_H) + ADDR_W'(cur_y_ff);

   // decision over center, up, right, down (registered) and left (arriving now)
   assign walker   = (cells_ff[0] == CELL_WALKER);
   assign near_agg = ((cur_y_ff != '0) && (cells_ff[1] == CELL_AGG)) ||
                     ((cur_x_ff != XW'(GRID_W - 1)) && (cells_ff[2] == CELL_AGG)) ||
                     ((cur_y_ff != YW'(GRID_H - 1)) && (cells_ff[3] == CELL_AGG)) ||
                     ((cur_x_ff != '0) && (rd_data == CELL_AGG));

   always_comb begin
      dir_moves = 1'b1;
      tgt_cell  = CELL_EMPTY;
      unique case (dir_ff)
         DIR_UP:    tgt_cell = cells_ff[1];
         DIR_RIGHT: tgt_cell = cells_ff[2];
         DIR_DOWN:  tgt_cell = cells_ff[3];
         DIR_LEFT:  tgt_cell = rd_data;
         default: begin
            dir_moves = 1'b0;
            tgt_cell  = CELL_WALKER;
         end
      endcase
   end

   assign move_ok    = walker && !near_agg && dir_moves && (tgt_cell == CELL_EMPTY);
   assign joined_inc = (joined_ff != COUNT_MAX) ? joined_ff + 1'b1 : joined_ff;

   always_comb begin
      state_in      = state_ff;
      scan_x_in     = scan_x_ff;
      scan_y_in     = scan_y_ff;
      joined_in     = joined_ff;
      run_over_in   = run_over_ff;
      probe_in      = probe_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      inside_in     = inside_ff;
      nv_in         = nv_ff;
      dir_in        = dir_ff;
      cells_in      = cells_ff;
      read_value_in = read_value_ff;
      stuck_in      = stuck_ff;
      done_in       = done_ff;
      in_ready      = 1'b0;
      res_valid     = 1'b0;
      mem_req       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            in_ready = !clear_busy;
            if (in_valid && !clear_busy) begin
               inside_in     = (32'(in_item.pos_x) < GRID_W) &&
                               (32'(in_item.pos_y) < GRID_H);
               nv_in         = in_item.new_value;
               dir_in        = in_item.direction;
               read_value_in = CELL_EMPTY;
               stuck_in      = 1'b0;
               done_in       = 1'b0;
               probe_in      = DIR_STAY;
               cur_x_in      = XW'(in_item.pos_x);
               cur_y_in      = YW'(in_item.pos_y);
               unique case (in_item.mode)
                  MODE_WRITE: state_in = ST_WRITE;
                  MODE_READ:  state_in = ST_READ_ISSUE;
                  MODE_STEP: begin
                     cur_x_in = scan_x_ff;
                     cur_y_in = scan_y_ff;
                     state_in = run_over_ff ? ST_RESULT : ST_PROBE;
                  end
                  MODE_NOP:   state_in = ST_RESULT;
               endcase
            end
         end

         ST_WRITE: begin
            mem_req.wr_en   = inside_ff && (nv_ff != CELL_NONE);
            mem_req.wr_addr = ctr_addr;
            mem_req.wr_data = nv_ff;
            state_in        = ST_RESULT;
         end

         ST_READ_ISSUE: begin
            mem_req.rd_en   = inside_ff;
            mem_req.rd_addr = ctr_addr;
            state_in        = ST_READ_TAKE;
         end

         ST_READ_TAKE: begin
            read_value_in = inside_ff ? rd_data : CELL_EMPTY;
            state_in      = ST_RESULT;
         end

         ST_PROBE: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = nb_addr;
            if (probe_ff != DIR_STAY) begin
               cells_in[2'(probe_ff - 3'd1)] = rd_data;
            end
            probe_in = probe_ff + 3'd1;
            if (probe_ff == DIR_LEFT) begin
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            state_in = ST_RESULT;
            if (walker && near_agg) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = ctr_addr;
               mem_req.wr_data = CELL_AGG;
               stuck_in        = 1'b1;
               joined_in       = joined_inc;
            end else if (move_ok) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = nb_addr;
               mem_req.wr_data = CELL_WALKER;
               state_in        = ST_MOVE_CLR;
            end
            // advance the raster position, y inner
            if (cur_y_ff == YW'(GRID_H - 1)) begin
               scan_y_in = '0;
               if (cur_x_ff == XW'(GRID_W - 1)) begin
                  scan_x_in   = '0;
                  done_in     = 1'b1;
                  run_over_in = ((walker && near_agg) ? joined_inc : joined_ff) >= target_count;
               end else begin
                  scan_x_in = cur_x_ff + 1'b1;
               end
            end else begin
               scan_x_in = cur_x_ff;
               scan_y_in = cur_y_ff + 1'b1;
            end
         end

         ST_MOVE_CLR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = ctr_addr;
            mem_req.wr_data = CELL_EMPTY;
            state_in        = ST_RESULT;
         end

         ST_RESULT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         scan_x_ff   <= '0;
         scan_y_ff   <= '0;
         joined_ff   <= '0;
         run_over_ff <= 1'b0;
         probe_ff    <= DIR_STAY;
      end else begin
         state_ff    <= state_in;
         scan_x_ff   <= scan_x_in;
         scan_y_ff   <= scan_y_in;
         joined_ff   <= joined_in;
         run_over_ff <= run_over_in;
         probe_ff    <= probe_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff      <= cur_x_in;
      cur_y_ff      <= cur_y_in;
      inside_ff     <= inside_in;
      nv_ff         <= nv_in;
      dir_ff        <= dir_in;
      cells_ff      <= cells_in;
      read_value_ff <= read_value_in;
      stuck_ff      <= stuck_in;
      done_ff       <= done_in;
   end

   assign res_item.read_value      = read_value_ff;
   assign res_item.stuck           = stuck_ff;
   assign res_item.aggregate_count = joined_ff;
   assign res_item.sweep_done      = done_ff;
   assign res_item.finished        = run_over_ff;

endmodule

[src/dla_grid_sweep_step.sv]
// Channel   Direction  Handshake              Payload
// req_      in         req_tvalid/req_tready  mode, pos_x, pos_y, new_value, direction
// rsp_      out        rsp_tvalid/rsp_tready  read_value, stuck, aggregate_count,
//                                             sweep_done, finished
// csr_      in         csr_wr_en              target_count
//
// The lattice memory has a single read port: a step reads the center and four
// neighbors one per cycle, then writes back up to two cells. Once the run is
// finished, a step reads and writes no cell.
// Reset clears the control state, then a clearing pass writes every lattice entry
// empty, one per cycle; req_tready stays low until it ends.
// The result register decouples the sides: a new transaction is accepted while a
// finished result still waits on rsp_tready.
module dla_grid_sweep_step
   import dgs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // req_tdata: mode[1:0], pos_x[11:2], pos_y[21:12], new_value[23:22],
   //            direction[26:24], zero[31:27]
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [31:0]      req_tdata,
   // rsp_tdata: read_value[1:0], stuck[2], aggregate_count[23:3], sweep_done[24],
   //            finished[25], zero[31:26]
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [31:0]      rsp_tdata,
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data
);

   logic [CNT_W-1:0]  target_ff, target_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_item_ff, rsp_item_in;
   req_item_type      req_item;
   rsp_item_type      res_item;
   logic              res_valid;
   logic              res_ready;
   mem_req_type       mem_req;
   logic [CELL_W-1:0] rd_data;
   logic              clear_busy;

   // unpack the request, drop the pad bits
   assign req_item = req_tdata[$bits(req_item_type)-1:0];

   dgs_sweep_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_item      (req_item),
      .target_count (target_ff),
      .res_valid    (res_valid),
      .res_ready    (res_ready),
      .res_item     (res_item),
      .mem_req      (mem_req),
      .rd_data      (rd_data),
      .clear_busy   (clear_busy)
   );

   dgs_lattice_mem u_mem (
      .clock      (clock),
      .reset      (reset),
      .mem_req    (mem_req),
      .rd_data    (rd_data),
      .clear_busy (clear_busy)
   );

   // target register, to be written only while idle; the block does not enforce it
   assign target_in = csr_wr_en ? csr_wr_data : target_ff;

   // result register: load when empty or being drained this cycle
   assign res_ready    = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = (res_valid && res_ready) || (rsp_valid_ff && !rsp_tready);
   assign rsp_item_in  = (res_valid && res_ready) ? res_item : rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= TARGET_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         target_ff    <= target_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(32 - $bits(rsp_item_type))'(0), rsp_item_ff};

`ifndef SYNTHESIS
   // no transaction enters while the clearing pass owns the memory
   a_no_accept_while_clearing : assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !req_tready)
      else $error("request accepted during lattice clearing");

   // controller writes never collide with the clearing pass
   a_no_write_while_clearing : assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en |-> !clear_busy)
      else $error("lattice write during clearing pass");

   // a joined walker always shows in the count
   a_stuck_counts : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.stuck) |-> (rsp_item_ff.aggregate_count != '0))
      else $error("stuck reported with zero aggregate count");

   // lattice never holds the unused cell code
   a_read_value_legal : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_item_ff.read_value != CELL_NONE))
      else $error("illegal cell code read back");
`endif

endmodule

[dv/dla_grid_sweep_step_check.sv]
module dla_grid_sweep_step_check
   import dgs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [31:0]      req_tdata,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [31:0]      rsp_tdata,
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data,
   output int unsigned      mismatch_count,
   output int unsigned      results_seen,
   output int unsigned      outstanding,
   output int unsigned      stuck_count
);

   // lattice mirror; it starts empty and reset comes only once
   bit [CELL_W-1:0]  cells [LAT_DEPTH];
   int               scan_x;
   int               scan_y;
   logic [CNT_W-1:0] joined_total;
   logic [CNT_W-1:0] target_count;
   logic             run_over;
   rsp_item_type     expected_rsp [$];

   function automatic logic [CELL_W-1:0] cell_at(input int x, input int y);
      return cells[x * GRID_H + y];
   endfunction

   function automatic void cell_put(input int x, input int y, input logic [CELL_W-1:0] v);
      cells[x * GRID_H + y] = v;
   endfunction

   // advance the mirror by one command and return the result it must produce
   function automatic rsp_item_type apply_lattice_cmd(input req_item_type c);
      rsp_item_type r;
      int           x;
      int           y;
      int           tx;
      int           ty;
      logic         on_grid;
      logic         near_agg;
      logic         moving;
      r = '0;
      on_grid = (int'(c.pos_x) < GRID_W) && (int'(c.pos_y) < GRID_H);
      case (c.mode)
         MODE_WRITE: begin
            if (on_grid && c.new_value != CELL_NONE)
               cell_put(int'(c.pos_x), int'(c.pos_y), c.new_value);
         end
         MODE_READ: begin
            if (on_grid)
               r.read_value = cell_at(int'(c.pos_x), int'(c.pos_y));
         end
         MODE_STEP: begin
            if (!run_over) begin
               x = scan_x;
               y = scan_y;
               if (cell_at(x, y) == CELL_WALKER) begin
                  // neighbor test stops at the lattice rim
                  near_agg = (x != 0 && cell_at(x - 1, y) == CELL_AGG) ||
                             (x != GRID_W - 1 && cell_at(x + 1, y) == CELL_AGG) ||
                             (y != 0 && cell_at(x, y - 1) == CELL_AGG) ||
                             (y != GRID_H - 1 && cell_at(x, y + 1) == CELL_AGG);
                  if (near_agg) begin
                     cell_put(x, y, CELL_AGG);
                     r.stuck = 1'b1;
                     if (joined_total != COUNT_MAX)
                        joined_total = joined_total + 1'b1;
                  end else begin
                     // moves wrap around the rim
                     tx = x;
                     ty = y;
                     moving = 1'b1;
                     case (c.direction)
                        DIR_UP:    ty = (y == 0) ? GRID_H - 1 : y - 1;
                        DIR_RIGHT: tx = (x == GRID_W - 1) ? 0 : x + 1;
                        DIR_DOWN:  ty = (y == GRID_H - 1) ? 0 : y + 1;
                        DIR_LEFT:  tx = (x == 0) ? GRID_W - 1 : x - 1;
                        default:   moving = 1'b0;
                     endcase
                     if (moving && cell_at(tx, ty) == CELL_EMPTY) begin
                        cell_put(tx, ty, CELL_WALKER);
                        cell_put(x, y, CELL_EMPTY);
                     end
                  end
               end
               y++;
               if (y >= GRID_H) begin
                  y = 0;
                  x++;
                  if (x >= GRID_W) begin
                     x = 0;
                     r.sweep_done = 1'b1;
                     if (joined_total >= target_count)
                        run_over = 1'b1;
                  end
               end
               scan_x = x;
               scan_y = y;
            end
         end
         default: ;
      endcase
      r.aggregate_count = joined_total;
      r.finished = run_over;
      return r;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (reset) begin
         scan_x = 0;
         scan_y = 0;
         joined_total = '0;
         run_over = 1'b0;
         target_count = TARGET_RESET;
         expected_rsp.delete();
         mismatch_count = 0;
         results_seen = 0;
         outstanding = 0;
         stuck_count = 0;
      end else begin
         if (csr_wr_en)
            target_count = csr_wr_data;
         // retire a result before taking a new command: it can never belong to it
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(rsp_item_type)-1:0];
            results_seen++;
            if (got.stuck)
               stuck_count++;
            if (expected_rsp.size() == 0) begin
               $error("unexpected result transaction, tdata %h", rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_rsp.pop_front();
               check_field("read_value", 32'(want.read_value), 32'(got.read_value));
               check_field("stuck", 32'(want.stuck), 32'(got.stuck));
               check_field("aggregate_count", 32'(want.aggregate_count),
                           32'(got.aggregate_count));
               check_field("sweep_done", 32'(want.sweep_done), 32'(got.sweep_done));
               check_field("finished", 32'(want.finished), 32'(got.finished));
            end
         end
         if (req_tvalid && req_tready)
            expected_rsp.push_back(apply_lattice_cmd(req_tdata[$bits(req_item_type)-1:0]));
         outstanding = expected_rsp.size();
      end
   end

endmodule

[dv/dla_grid_sweep_step_tb.sv]
module dla_grid_sweep_step_tb;
   import dgs_pkg::*;

   // the limit covers the clearing pass plus the traffic, even with the heaviest stalls
   localparam int unsigned CYCLE_LIMIT     = 5000000;
   localparam int unsigned ITEMS_PER_PHASE = 430;
   localparam int unsigned HOLD_CYCLES     = 400;
   localparam int unsigned DRAIN_CYCLES    = 16;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [31:0]      req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [31:0]      rsp_tdata;
   logic             csr_wr_en = 1'b0;
   logic [CNT_W-1:0] csr_wr_data = '0;

   int unsigned mismatch_count;
   int unsigned results_seen;
   int unsigned outstanding;
   int unsigned stuck_count;

   int unsigned cycle_count = 0;
   int unsigned sent_count = 0;
   int unsigned steps_sent = 0;
   int          tx_idle_pct = 0;
   int          rx_idle_pct = 30;
   logic        hold_request = 1'b0;
   logic        hold_done = 1'b0;
   int unsigned hold_left = 0;

   always #5 clock = ~clock;

   dla_grid_sweep_step DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   dla_grid_sweep_step_check u_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .results_seen   (results_seen),
      .outstanding    (outstanding),
      .stuck_count    (stuck_count)
   );

   // Result side: random back-pressure, plus one long hold once requested so the
   // result register fills, the step engine backs up and req_tready drops.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Watchdog: end the run once the cycle count reaches CYCLE_LIMIT.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("watchdog expired after %0d cycles", cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Offer one command transaction and hold it until accepted. Idle cycles go in
   // front of it; back-to-back offers keep tvalid high without a dip.
   task automatic push_cmd(input logic [MODE_W-1:0] mode, input int x, input int y,
                           input logic [CELL_W-1:0] value, input logic [DIR_W-1:0] dir);
      req_item_type cmd;
      cmd.mode      = mode;
      cmd.pos_x     = POS_W'(x);
      cmd.pos_y     = POS_W'(y);
      cmd.new_value = value;
      cmd.direction = dir;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= 32'(cmd);
      do @(posedge clock); while (!req_tready);
      sent_count++;
      if (mode == MODE_STEP)
         steps_sent++;
   endtask

   // Wait until every command has its result back; the block is then idle.
   task automatic wait_drained();
      while (results_seen != sent_count)
         @(posedge clock);
   endtask

   task automatic write_target(input logic [CNT_W-1:0] value);
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   // Pick the center or one of its four neighbors, wrapping at the rim.
   function automatic void pick_near(input int sx, input int sy, output int nx, output int ny);
      nx = sx;
      ny = sy;
      case ($urandom_range(4))
         0: nx = (sx + GRID_W - 1) % GRID_W;
         1: nx = (sx + 1) % GRID_W;
         2: ny = (sy + GRID_H - 1) % GRID_H;
         3: ny = (sy + 1) % GRID_H;
         default: ;
      endcase
   endfunction

   // Well-formed step: plant a walker on the cell the sweep visits next, dress up
   // its neighborhood (aggregate, blockers, walkers further down the sweep),
   // step with a random direction, then sometimes read back around it.
   task automatic seeded_step();
      int               sx;
      int               sy;
      int               nx;
      int               ny;
      logic [CELL_W-1:0] v;
      sx = steps_sent / GRID_H;
      sy = steps_sent % GRID_H;
      push_cmd(MODE_WRITE, sx, sy, CELL_WALKER, DIR_W'($urandom_range(7)));
      repeat ($urandom_range(3)) begin
         if ($urandom_range(3) == 0) begin
            push_cmd(MODE_WRITE, sx, (sy + $urandom_range(1, 4)) % GRID_H, CELL_WALKER,
                     DIR_W'($urandom_range(7)));
         end else begin
            pick_near(sx, sy, nx, ny);
            v = $urandom_range(1) ? CELL_AGG : CELL_W'($urandom_range(3));
            push_cmd(MODE_WRITE, nx, ny, v, DIR_W'($urandom_range(7)));
         end
      end
      push_cmd(MODE_STEP, $urandom_range(1023), $urandom_range(1023),
               CELL_W'($urandom_range(3)), DIR_W'($urandom_range(7)));
      if ($urandom_range(1)) begin
         pick_near(sx, sy, nx, ny);
         push_cmd(MODE_READ, nx, ny, CELL_W'($urandom_range(3)), DIR_W'($urandom_range(7)));
      end
   endtask

   initial begin
      int unsigned phase_start;
      int unsigned step_goal;
      int unsigned roll;
      int          sy;

      // hold reset, then wait out the clearing pass
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (!req_tready);
      write_target(COUNT_MAX);

      // Directed part. The sweep visits (0,0), (0,1), ... in order.
      push_cmd(MODE_READ, 0, 0, CELL_EMPTY, DIR_STAY);               // fresh lattice
      push_cmd(MODE_READ, GRID_W - 1, GRID_H - 1, CELL_EMPTY, DIR_STAY);
      push_cmd(MODE_WRITE, GRID_W - 1, GRID_H - 1, CELL_AGG, DIR_STAY);
      push_cmd(MODE_WRITE, GRID_W - 1, GRID_H - 1, CELL_NONE, DIR_STAY); // drop value 3
      push_cmd(MODE_READ, GRID_W - 1, GRID_H - 1, CELL_EMPTY, DIR_STAY);
      push_cmd(MODE_NOP, GRID_W - 1, 0, CELL_AGG, 3'd7);
      // aggregate only across the left rim: no join, and the wrapped move is blocked
      push_cmd(MODE_WRITE, 0, 0, CELL_WALKER, DIR_STAY);
      push_cmd(MODE_WRITE, GRID_W - 1, 0, CELL_AGG, DIR_STAY);
      push_cmd(MODE_STEP, 0, 0, CELL_EMPTY, DIR_LEFT);
      push_cmd(MODE_READ, 0, 0, CELL_EMPTY, DIR_STAY);
      // move left across the rim into an empty cell
      push_cmd(MODE_WRITE, 0, 1, CELL_WALKER, DIR_STAY);
      push_cmd(MODE_STEP, 0, 0, CELL_EMPTY, DIR_LEFT);
      push_cmd(MODE_READ, GRID_W - 1, 1, CELL_EMPTY, DIR_STAY);
      // walker moves down the sweep and gets visited again, then joins
      push_cmd(MODE_WRITE, 0, 2, CELL_WALKER, DIR_STAY);
      push_cmd(MODE_WRITE, 1, 3, CELL_AGG, DIR_STAY);
      push_cmd(MODE_STEP, 0, 0, CELL_EMPTY, DIR_DOWN);
      push_cmd(MODE_STEP, 0, 0, CELL_EMPTY, DIR_STAY);
      // walker beside the aggregate at (0,3) joins, whatever the unknown direction
      push_cmd(MODE_WRITE, 0, 4, CELL_WALKER, DIR_STAY);
      push_cmd(MODE_STEP, 0, 0, CELL_EMPTY, 3'd5);
      // visited cell holds aggregate: nothing moves
      push_cmd(MODE_WRITE, 0, 5, CELL_AGG, DIR_STAY);
      push_cmd(MODE_STEP, 0, 0, CELL_EMPTY, DIR_UP);
      push_cmd(MODE_READ, 0, 3, CELL_EMPTY, DIR_STAY);
      push_cmd(MODE_READ, 0, 4, CELL_EMPTY, DIR_STAY);
      req_tvalid <= 1'b0;
      wait_drained();
      write_target('0);

      // Random part in three traffic mixes. Each sends at least ITEMS_PER_PHASE commands
      // and runs until the sweep covers its share of the first column, wrapping into the next.
      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin
               tx_idle_pct = 10;
               rx_idle_pct = 87;
            end
            1: begin
               tx_idle_pct = 87;
               rx_idle_pct = 10;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
               hold_request <= 1'b1;
            end
         endcase
         phase_start = sent_count;
         step_goal = (GRID_H + 16) * (p + 1) / 3;
         while (sent_count - phase_start < ITEMS_PER_PHASE || steps_sent < step_goal) begin
            roll = $urandom_range(99);
            sy = steps_sent % GRID_H;
            // always dress the cells next to the top and bottom rows
            if (roll < 8 || sy == 0 || sy >= GRID_H - 2)
               seeded_step();
            else if (roll < 97)
               push_cmd(MODE_STEP, $urandom_range(1023), $urandom_range(1023),
                        CELL_W'($urandom_range(3)), DIR_W'($urandom_range(7)));
            else
               push_cmd(MODE_W'($urandom_range(3)), $urandom_range(1023),
                        $urandom_range(1023), CELL_W'($urandom_range(3)),
                        DIR_W'($urandom_range(7)));
         end
         req_tvalid <= 1'b0;
         wait_drained();
         case (p)
            0: write_target(CNT_W'($urandom_range(1, 32'(COUNT_MAX) - 1)));
            1: write_target(CNT_W'(1048576));
            default: ;
         endcase
      end

      // let the last step finish its write-back before the verdict
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d commands, %0d of them sweep steps (sweep now at column %0d row %0d).",
               sent_count, steps_sent, steps_sent / GRID_H, steps_sent % GRID_H);
      $display("%0d walkers joined; target took 4 settings; %0d-cycle result hold applied.",
               stuck_count, HOLD_CYCLES);
      if (mismatch_count == 0 && outstanding == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
